// ===== sv/hbdrc_pkg.sv =====
package hbdrc_pkg;

  // Command codes carried in the mode field of an input word.
  typedef enum logic [2:0] {
    MODE_TICK    = 3'd0,
    MODE_ENABLE  = 3'd1,
    MODE_DIR     = 3'd2,
    MODE_DUTY    = 3'd3,
    MODE_SAFE    = 3'd4
  } mode_e;

  // Bridge drive codes, shared by the requested direction and the driven bridge.
  typedef enum logic [1:0] {
    BR_COAST = 2'd0,
    BR_FWD   = 2'd1,
    BR_REV   = 2'd2,
    BR_BRAKE = 2'd3
  } bridge_e;

  // Phases of the reversal sequence.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DOWN  = 2'd1,
    PH_COAST = 2'd2,
    PH_UP    = 2'd3
  } phase_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DUTY_STEP = 2'd0;
  localparam logic [1:0] CFG_STEP_TICKS = 2'd1;
  localparam logic [1:0] CFG_DEADTIME = 2'd2;

  localparam logic [6:0]  DUTY_MAX = 7'd100;
  localparam logic [6:0]  DUTY_STEP_RST = 7'd10;
  localparam logic [15:0] STEP_TICKS_RST = 16'd2000;
  localparam logic [15:0] DEADTIME_RST = 16'd2;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] direction;
    logic [7:0] duty;
    logic       enable_flag;
  } in_word_t;

  typedef struct packed {
    logic [1:0] bridge_state;
    logic [6:0] pwm_duty_out;
    logic       pwm_on;
    logic       is_enabled;
    logic [1:0] direction_now;
    logic [6:0] duty_now;
    logic       busy_res;
    logic       rejected;
  } out_word_t;

  typedef struct packed {
    logic [6:0]  duty_step;
    logic [15:0] step_ticks;
    logic [15:0] deadtime_ticks;
  } cfg_t;

  // Controller state apart from the tick counter, whose width is a parameter.
  typedef struct packed {
    logic       enabled;
    logic [1:0] direction;
    logic [6:0] stored_duty;
    logic [6:0] applied_duty;
    logic       pwm_running;
    logic [1:0] bridge;
    phase_e     phase;
    logic [7:0] ramp_value;
    logic [1:0] target_dir;
    logic [6:0] target_duty;
  } ctrl_state_t;

endpackage

// ===== sv/hbridge_direction_ramp_control.sv =====
// H-bridge direction and ramp controller.
// Command words arrive on the input channel (in_valid_i / in_ready_o, payload
// in_data_i): ticks of one microsecond, set enable, set direction, set duty and
// safe set. Every accepted word produces exactly one result word on the output
// channel (out_valid_o / out_ready_i, payload out_data_o) holding the bridge
// state, applied and stored duty, PWM and enable flags, the busy flag and
// whether the command was rejected because a reversal sequence was running.
// A word's result is registered and shown on the cycle after acceptance, and one
// word per cycle is sustained while the receiver takes every result. The input is
// ready whenever the result register is empty or being emptied in that cycle,
// so a receiver stall holds the result and stalls the input behind it.
// Configuration is written through cfg_valid_i / cfg_index_i / cfg_data_i,
// which is always ready; writes are expected only while no word is in flight.
// Reset leaves the bridge disabled and coasting with zero duty, the sequence
// idle and the registers at duty step 10, step time 2000 and dead time 2.
// COUNT_BITS sets the width of the hold counter used during the sequence.
module hbridge_direction_ramp_control #(
  parameter int COUNT_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  hbdrc_pkg::in_word_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output hbdrc_pkg::out_word_t out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  hbdrc_pkg::cfg_t        cfg_q;
  hbdrc_pkg::ctrl_state_t state_q;
  hbdrc_pkg::ctrl_state_t state_d;
  logic [COUNT_BITS-1:0]  cnt_q;
  logic [COUNT_BITS-1:0]  cnt_d;
  hbdrc_pkg::out_word_t   out_data_q;
  hbdrc_pkg::out_word_t   out_data_d;
  logic                   out_valid_q;
  logic                   in_fire;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire = in_valid_i && in_ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duty_step <= hbdrc_pkg::DUTY_STEP_RST;
      cfg_q.step_ticks <= hbdrc_pkg::STEP_TICKS_RST;
      cfg_q.deadtime_ticks <= hbdrc_pkg::DEADTIME_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        hbdrc_pkg::CFG_DUTY_STEP: cfg_q.duty_step <= cfg_data_i[6:0];
        hbdrc_pkg::CFG_STEP_TICKS: cfg_q.step_ticks <= cfg_data_i;
        hbdrc_pkg::CFG_DEADTIME: cfg_q.deadtime_ticks <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  hbdrc_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .state_i (state_q),
    .cnt_i   (cnt_q),
    .cfg_i   (cfg_q),
    .word_i  (in_data_i),
    .state_o (state_d),
    .cnt_o   (cnt_d),
    .word_o  (out_data_d)
  );

  // Controller state advances once per accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      cnt_q <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  // Result register and its valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;

`ifndef SYNTHESIS
  // A rejected command is only ever reported while the sequence is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.rejected |-> out_data_o.busy_res)
    else $error("rejected result without busy sequence");

  // PWM runs only while enabled and driving forward or reverse.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.pwm_on |-> out_data_o.is_enabled &&
      (out_data_o.bridge_state == hbdrc_pkg::BR_FWD ||
       out_data_o.bridge_state == hbdrc_pkg::BR_REV))
    else $error("PWM running on a bridge that is not driving");

  // Both duties stay within the percentage range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.duty_now <= hbdrc_pkg::DUTY_MAX &&
      out_data_o.pwm_duty_out <= hbdrc_pkg::DUTY_MAX)
    else $error("duty above maximum");

  // The hold counter rests at zero outside the reversal sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == hbdrc_pkg::PH_IDLE |-> cnt_q == '0)
    else $error("hold counter not cleared while idle");
`endif

endmodule

// ===== sv/hbdrc_step.sv =====
module hbdrc_step #(
  parameter int COUNT_BITS = 16
) (
  input  hbdrc_pkg::ctrl_state_t state_i,
  input  logic [COUNT_BITS-1:0]  cnt_i,
  input  hbdrc_pkg::cfg_t        cfg_i,
  input  hbdrc_pkg::in_word_t    word_i,
  output hbdrc_pkg::ctrl_state_t state_o,
  output logic [COUNT_BITS-1:0]  cnt_o,
  output hbdrc_pkg::out_word_t   word_o
);

  localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  // True for the codes that drive the motor and so run the PWM.
  function automatic logic drives(logic [1:0] d);
    return (d == hbdrc_pkg::BR_FWD) || (d == hbdrc_pkg::BR_REV);
  endfunction

  // Store a direction and drive it if the bridge is enabled.
  function automatic hbdrc_pkg::ctrl_state_t apply_mode(hbdrc_pkg::ctrl_state_t s,
                                                        logic [1:0] d);
    hbdrc_pkg::ctrl_state_t r;
    r = s;
    r.direction = d;
    if (!r.enabled) begin
      r.bridge = hbdrc_pkg::BR_COAST;
      r.pwm_running = 1'b0;
    end else begin
      r.bridge = d;
      r.pwm_running = drives(d);
    end
    return r;
  endfunction

  // Store a duty and apply it only while enabled and driving forward or reverse.
  function automatic hbdrc_pkg::ctrl_state_t apply_speed(hbdrc_pkg::ctrl_state_t s,
                                                         logic [6:0] d);
    hbdrc_pkg::ctrl_state_t r;
    r = s;
    r.stored_duty = d;
    if (r.enabled && drives(r.direction)) begin
      r.applied_duty = d;
      r.pwm_running = 1'b1;
    end else begin
      r.applied_duty = '0;
      r.pwm_running = 1'b0;
    end
    return r;
  endfunction

  // Begin the ramp up in the target direction from zero duty.
  function automatic hbdrc_pkg::ctrl_state_t start_up(hbdrc_pkg::ctrl_state_t s);
    hbdrc_pkg::ctrl_state_t r;
    r = apply_mode(s, s.target_dir);
    r = apply_speed(r, '0);
    r.ramp_value = '0;
    r.phase = hbdrc_pkg::PH_UP;
    return r;
  endfunction

  hbdrc_pkg::ctrl_state_t s;
  logic [COUNT_BITS-1:0]  cnt;
  logic [COUNT_BITS-1:0]  cnt_inc;
  logic [15:0]            limit;
  logic                   hold_done;
  logic [6:0]             stp;
  logic [6:0]             duty_c;
  logic [7:0]             up_val;
  logic                   rej;

  // Hold counter: advances on each tick and ends at the limit or at all ones.
  assign cnt_inc = cnt_i + COUNT_BITS'(1);
  assign limit = (state_i.phase == hbdrc_pkg::PH_COAST) ? cfg_i.deadtime_ticks
                                                        : cfg_i.step_ticks;
  assign hold_done = (CMP_W'(cnt_inc) >= CMP_W'(limit)) || (cnt_inc == '1);

  // A zero step size behaves as one, and requested duty is clamped.
  assign stp = (cfg_i.duty_step == '0) ? 7'd1 : cfg_i.duty_step;
  assign duty_c = (word_i.duty > {1'b0, hbdrc_pkg::DUTY_MAX}) ? hbdrc_pkg::DUTY_MAX
                                                              : word_i.duty[6:0];
  assign up_val = state_i.ramp_value + {1'b0, stp};

  // Next state for one command word.
  always_comb begin
    s = state_i;
    cnt = cnt_i;
    rej = 1'b0;
    if (word_i.mode == hbdrc_pkg::MODE_TICK) begin
      if (state_i.phase != hbdrc_pkg::PH_IDLE) begin
        cnt = hold_done ? '0 : cnt_inc;
      end
      case (state_i.phase)
        hbdrc_pkg::PH_DOWN: begin
          if (hold_done) begin
            if (state_i.ramp_value >= {1'b0, stp}) begin
              s.ramp_value = state_i.ramp_value - {1'b0, stp};
              s = apply_speed(s, s.ramp_value[6:0]);
            end else begin
              s.bridge = hbdrc_pkg::BR_COAST;
              s.pwm_running = 1'b0;
              s.phase = hbdrc_pkg::PH_COAST;
              if (cfg_i.deadtime_ticks == '0) begin
                s = start_up(s);
              end
            end
          end
        end
        hbdrc_pkg::PH_COAST: begin
          if (hold_done) begin
            s = start_up(s);
          end
        end
        hbdrc_pkg::PH_UP: begin
          if (hold_done) begin
            if (state_i.ramp_value >= {1'b0, state_i.target_duty}) begin
              s.phase = hbdrc_pkg::PH_IDLE;
            end else begin
              s.ramp_value = (up_val > {1'b0, state_i.target_duty}) ?
                             {1'b0, state_i.target_duty} : up_val;
              s = apply_speed(s, s.ramp_value[6:0]);
            end
          end
        end
        default: begin
        end
      endcase
    end else if (state_i.phase != hbdrc_pkg::PH_IDLE) begin
      rej = 1'b1;
    end else begin
      case (word_i.mode)
        hbdrc_pkg::MODE_ENABLE: begin
          s.enabled = word_i.enable_flag;
          if (!word_i.enable_flag) begin
            s.applied_duty = '0;
            s.pwm_running = 1'b0;
            s.bridge = hbdrc_pkg::BR_COAST;
          end else begin
            s = apply_mode(s, s.direction);
            s = apply_speed(s, s.stored_duty);
          end
        end
        hbdrc_pkg::MODE_DIR: begin
          s = apply_mode(s, word_i.direction);
        end
        hbdrc_pkg::MODE_DUTY: begin
          s = apply_speed(s, duty_c);
        end
        hbdrc_pkg::MODE_SAFE: begin
          // Swapping forward and reverse while enabled starts the sequence.
          if (state_i.enabled &&
              (((state_i.direction == hbdrc_pkg::BR_FWD) &&
                (word_i.direction == hbdrc_pkg::BR_REV)) ||
               ((state_i.direction == hbdrc_pkg::BR_REV) &&
                (word_i.direction == hbdrc_pkg::BR_FWD)))) begin
            s.target_dir = word_i.direction;
            s.target_duty = duty_c;
            s.ramp_value = {1'b0, state_i.stored_duty};
            s = apply_speed(s, state_i.stored_duty);
            s.phase = hbdrc_pkg::PH_DOWN;
            cnt = '0;
          end else begin
            s = apply_mode(s, word_i.direction);
            s = apply_speed(s, duty_c);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign state_o = s;
  assign cnt_o = cnt;

  // Result word reflects the state after the command.
  always_comb begin
    word_o.bridge_state = s.bridge;
    word_o.pwm_duty_out = s.applied_duty;
    word_o.pwm_on = s.pwm_running;
    word_o.is_enabled = s.enabled;
    word_o.direction_now = s.direction;
    word_o.duty_now = s.stored_duty;
    word_o.busy_res = (s.phase != hbdrc_pkg::PH_IDLE);
    word_o.rejected = rej;
  end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Mode codes the package leaves unnamed; the block must ignore them.
  localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] MODE_UNUSED_LAST = 3'd7;

  // Whether a directed row carries its own expected word or uses the predictor.
  localparam bit FIXED = 1'b1;
  localparam bit PREDICT = 1'b0;

  localparam int BRIEF_ITEMS = 15;
  localparam int PHASE_ITEMS = 90;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_OFF_FIRST = 300;
  localparam int HOLD_OFF_LAST = 359;
  localparam int STEADY_FIRST = 600;
  localparam int STEADY_LAST = 850;
  localparam int IDLE_PERCENT = 28;

  typedef struct packed {
    hbdrc_pkg::in_word_t  cmd;
    logic                 typed;
    hbdrc_pkg::out_word_t want;
  } probe_t;

  localparam hbdrc_pkg::out_word_t NO_WORD = '0;
  // State held by the reversal started in the directed rows, with the rejected flag set.
  localparam hbdrc_pkg::out_word_t BUSY_REJECT =
    '{hbdrc_pkg::BR_REV, 7'd60, 1'b1, 1'b1, hbdrc_pkg::BR_REV, 7'd60, 1'b1, 1'b1};

  localparam probe_t DIRECTED [21] = '{
    '{'{hbdrc_pkg::MODE_TICK, hbdrc_pkg::BR_COAST, 8'd0, 1'b0}, FIXED,
      '{hbdrc_pkg::BR_COAST, 7'd0, 1'b0, 1'b0, hbdrc_pkg::BR_COAST, 7'd0, 1'b0, 1'b0}},
    '{'{hbdrc_pkg::MODE_DUTY, hbdrc_pkg::BR_BRAKE, 8'd255, 1'b1}, FIXED,
      '{hbdrc_pkg::BR_COAST, 7'd0, 1'b0, 1'b0, hbdrc_pkg::BR_COAST, 7'd100, 1'b0, 1'b0}},
    '{'{hbdrc_pkg::MODE_DIR, hbdrc_pkg::BR_FWD, 8'd0, 1'b0}, PREDICT, NO_WORD},
    '{'{hbdrc_pkg::MODE_ENABLE, hbdrc_pkg::BR_REV, 8'd17, 1'b1}, PREDICT, NO_WORD},
    '{'{hbdrc_pkg::MODE_DUTY, hbdrc_pkg::BR_FWD, 8'd0, 1'b0}, PREDICT, NO_WORD},
    '{'{hbdrc_pkg::MODE_DUTY, hbdrc_pkg::BR_COAST, 8'd100, 1'b0}, FIXED,
      '{hbdrc_pkg::BR_FWD, 7'd100, 1'b1, 1'b1, hbdrc_pkg::BR_FWD, 7'd100, 1'b0, 1'b0}},
    '{'{hbdrc_pkg::MODE_DIR, hbdrc_pkg::BR_BRAKE, 8'd128, 1'b0}, PREDICT, NO_WORD},
    '{'{hbdrc_pkg::MODE_DUTY, hbdrc_pkg::BR_COAST, 8'd50, 1'b1}, PREDICT, NO_WORD},
    '{'{hbdrc_pkg::MODE_DIR, hbdrc_pkg::BR_COAST, 8'd0, 1'b1}, PREDICT, NO_WORD},
    '{'{hbdrc_pkg::MODE_SAFE, hbdrc_pkg::BR_FWD, 8'd200, 1'b0}, PREDICT, NO_WORD},
    '{'{MODE_UNUSED_FIRST, hbdrc_pkg::BR_REV, 8'd9, 1'b1}, PREDICT, NO_WORD},
    '{'{hbdrc_pkg::MODE_ENABLE, hbdrc_pkg::BR_COAST, 8'd0, 1'b0}, PREDICT, NO_WORD},
    '{'{hbdrc_pkg::MODE_SAFE, hbdrc_pkg::BR_REV, 8'd60, 1'b1}, PREDICT, NO_WORD},
    '{'{hbdrc_pkg::MODE_ENABLE, hbdrc_pkg::BR_FWD, 8'd0, 1'b1}, PREDICT, NO_WORD},
    '{'{hbdrc_pkg::MODE_SAFE, hbdrc_pkg::BR_FWD, 8'd255, 1'b0}, PREDICT, NO_WORD},
    '{'{hbdrc_pkg::MODE_DUTY, hbdrc_pkg::BR_COAST, 8'd7, 1'b0}, FIXED, BUSY_REJECT},
    '{'{hbdrc_pkg::MODE_ENABLE, hbdrc_pkg::BR_COAST, 8'd0, 1'b0}, FIXED, BUSY_REJECT},
    '{'{MODE_UNUSED_LAST, hbdrc_pkg::BR_BRAKE, 8'd255, 1'b1}, FIXED, BUSY_REJECT},
    '{'{hbdrc_pkg::MODE_SAFE, hbdrc_pkg::BR_REV, 8'd0, 1'b0}, FIXED, BUSY_REJECT},
    '{'{hbdrc_pkg::MODE_TICK, hbdrc_pkg::BR_BRAKE, 8'd255, 1'b1}, PREDICT, NO_WORD},
    '{'{hbdrc_pkg::MODE_DIR, hbdrc_pkg::BR_REV, 8'd1, 1'b0}, PREDICT, NO_WORD}
  };

  // Register settings, one per random phase. The first holds the extremes and
  // is kept brief, since a hold of 65535 ticks cannot be waited out.
  localparam hbdrc_pkg::cfg_t REG_PHASES [6] = '{
    '{7'd100, 16'd65535, 16'd65535},
    '{7'd25, 16'd1, 16'd0},
    '{7'd0, 16'd0, 16'd1},
    '{7'd7, 16'd2, 16'd3},
    '{7'd1, 16'd1, 16'd0},
    '{7'd100, 16'd3, 16'd2}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  hbdrc_pkg::in_word_t  in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  hbdrc_pkg::out_word_t out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [1:0]           cfg_index_i = hbdrc_pkg::CFG_DUTY_STEP;
  logic [15:0]          cfg_data_i = '0;

  // Predicted controller state and register values.
  logic                drv_enabled = 1'b0;
  hbdrc_pkg::bridge_e  drv_direction = hbdrc_pkg::BR_COAST;
  logic [6:0]          drv_stored_duty = '0;
  logic [6:0]          drv_applied_duty = '0;
  logic                drv_pwm = 1'b0;
  hbdrc_pkg::bridge_e  drv_bridge = hbdrc_pkg::BR_COAST;
  hbdrc_pkg::phase_e   drv_phase = hbdrc_pkg::PH_IDLE;
  logic [7:0]          drv_ramp = '0;
  hbdrc_pkg::bridge_e  drv_target_dir = hbdrc_pkg::BR_COAST;
  logic [6:0]          drv_target_duty = '0;
  logic [15:0]         drv_hold = '0;
  hbdrc_pkg::cfg_t     drv_cfg = '{hbdrc_pkg::DUTY_STEP_RST, hbdrc_pkg::STEP_TICKS_RST,
                                   hbdrc_pkg::DEADTIME_RST};

  hbdrc_pkg::out_word_t expected_words [$];
  int                   mismatches = 0;
  int                   commands_applied = 0;
  bit                   sender_steady = 1'b0;

  hbridge_direction_ramp_control uut (.*);

  always #5ns clk_i = ~clk_i;

  function automatic logic [6:0] clamp_duty(int unsigned v);
    return v > hbdrc_pkg::DUTY_MAX ? hbdrc_pkg::DUTY_MAX : 7'(v);
  endfunction

  // Stores a direction and drives the bridge from it, only while enabled.
  function automatic void steer(hbdrc_pkg::bridge_e d);
    drv_direction = d;
    if (!drv_enabled) begin
      drv_bridge = hbdrc_pkg::BR_COAST;
      drv_pwm = 1'b0;
    end else begin
      drv_bridge = d;
      drv_pwm = d inside {hbdrc_pkg::BR_FWD, hbdrc_pkg::BR_REV};
    end
  endfunction

  // Stores a duty; it reaches the PWM only while enabled and driving.
  function automatic void set_speed(int unsigned d);
    drv_stored_duty = clamp_duty(d);
    if (drv_enabled && drv_direction inside {hbdrc_pkg::BR_FWD, hbdrc_pkg::BR_REV}) begin
      drv_applied_duty = drv_stored_duty;
      drv_pwm = 1'b1;
    end else begin
      drv_applied_duty = '0;
      drv_pwm = 1'b0;
    end
  endfunction

  // Counts one tick of a hold; the counter saturating also ends the hold.
  function automatic logic hold_expired(logic [15:0] limit);
    logic [15:0] cnt;
    cnt = drv_hold + 16'd1;
    if (cnt >= limit || cnt == '1) begin
      drv_hold = '0;
      return 1'b1;
    end
    drv_hold = cnt;
    return 1'b0;
  endfunction

  function automatic void start_ramp_up();
    steer(drv_target_dir);
    set_speed(0);
    drv_ramp = '0;
    drv_phase = hbdrc_pkg::PH_UP;
    drv_hold = '0;
  endfunction

  // One tick of the reversal: ramp down, coast for the dead time, ramp up.
  function automatic void tick_sequence();
    int unsigned stp;
    int unsigned nv;
    stp = drv_cfg.duty_step == 0 ? 1 : drv_cfg.duty_step;
    case (drv_phase)
      hbdrc_pkg::PH_DOWN: begin
        if (hold_expired(drv_cfg.step_ticks)) begin
          if (drv_ramp >= stp) begin
            drv_ramp = 8'(drv_ramp - stp);
            set_speed(drv_ramp);
          end else begin
            drv_bridge = hbdrc_pkg::BR_COAST;
            drv_pwm = 1'b0;
            drv_phase = hbdrc_pkg::PH_COAST;
            drv_hold = '0;
            // With no dead time the ramp up begins on this same tick.
            if (drv_cfg.deadtime_ticks == 0) start_ramp_up();
          end
        end
      end
      hbdrc_pkg::PH_COAST: begin
        if (hold_expired(drv_cfg.deadtime_ticks)) start_ramp_up();
      end
      hbdrc_pkg::PH_UP: begin
        if (hold_expired(drv_cfg.step_ticks)) begin
          if (drv_ramp >= drv_target_duty) begin
            drv_phase = hbdrc_pkg::PH_IDLE;
            drv_hold = '0;
          end else begin
            nv = drv_ramp + stp;
            drv_ramp = nv > drv_target_duty ? 8'(drv_target_duty) : 8'(nv);
            set_speed(drv_ramp);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Applies one command word to the predicted state and returns the result word.
  function automatic hbdrc_pkg::out_word_t predict_bridge_word(hbdrc_pkg::in_word_t w);
    hbdrc_pkg::out_word_t res;
    hbdrc_pkg::bridge_e   req;
    logic                 swap;
    res = '0;
    req = hbdrc_pkg::bridge_e'(w.direction);
    if (w.mode == hbdrc_pkg::MODE_TICK) begin
      tick_sequence();
    end else if (drv_phase != hbdrc_pkg::PH_IDLE) begin
      res.rejected = 1'b1;
    end else begin
      case (w.mode)
        hbdrc_pkg::MODE_ENABLE: begin
          drv_enabled = w.enable_flag;
          if (!w.enable_flag) begin
            drv_applied_duty = '0;
            drv_pwm = 1'b0;
            drv_bridge = hbdrc_pkg::BR_COAST;
          end else begin
            steer(drv_direction);
            set_speed(drv_stored_duty);
          end
        end
        hbdrc_pkg::MODE_DIR: steer(req);
        hbdrc_pkg::MODE_DUTY: set_speed(w.duty);
        hbdrc_pkg::MODE_SAFE: begin
          swap = (drv_direction == hbdrc_pkg::BR_FWD && req == hbdrc_pkg::BR_REV) ||
                 (drv_direction == hbdrc_pkg::BR_REV && req == hbdrc_pkg::BR_FWD);
          if (swap && drv_enabled) begin
            drv_target_dir = req;
            drv_target_duty = clamp_duty(w.duty);
            drv_ramp = {1'b0, drv_stored_duty};
            set_speed(drv_stored_duty);
            drv_phase = hbdrc_pkg::PH_DOWN;
            drv_hold = '0;
          end else begin
            steer(req);
            set_speed(w.duty);
          end
        end
        default: ;
      endcase
    end
    res.bridge_state = drv_bridge;
    res.pwm_duty_out = drv_applied_duty;
    res.pwm_on = drv_pwm;
    res.is_enabled = drv_enabled;
    res.direction_now = drv_direction;
    res.duty_now = drv_stored_duty;
    res.busy_res = drv_phase != hbdrc_pkg::PH_IDLE;
    return res;
  endfunction

  // Mostly ticks while a reversal runs, so that sequences reach their end;
  // when idle, safe sets usually ask for the opposite direction.
  function automatic hbdrc_pkg::in_word_t random_command();
    hbdrc_pkg::in_word_t w;
    int unsigned         pick;
    w.direction = 2'($urandom_range(3));
    w.duty = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(100));
    w.enable_flag = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (drv_phase != hbdrc_pkg::PH_IDLE) begin
      w.mode = pick < 85 ? hbdrc_pkg::MODE_TICK :
               3'($urandom_range(hbdrc_pkg::MODE_ENABLE, MODE_UNUSED_LAST));
    end else if (pick < 30) begin
      w.mode = hbdrc_pkg::MODE_TICK;
    end else if (pick < 52) begin
      w.mode = hbdrc_pkg::MODE_SAFE;
      if (drv_direction inside {hbdrc_pkg::BR_FWD, hbdrc_pkg::BR_REV} &&
          $urandom_range(99) < 75)
        w.direction = drv_direction == hbdrc_pkg::BR_FWD ? hbdrc_pkg::BR_REV
                                                          : hbdrc_pkg::BR_FWD;
    end else if (pick < 67) begin
      w.mode = hbdrc_pkg::MODE_DUTY;
    end else if (pick < 79) begin
      w.mode = hbdrc_pkg::MODE_DIR;
    end else if (pick < 95) begin
      w.mode = hbdrc_pkg::MODE_ENABLE;
      w.enable_flag = $urandom_range(99) < 80;
    end else begin
      w.mode = 3'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
    end
    return w;
  endfunction

  // Offers one command word, waits for it to be taken and records its result.
  task automatic send_command(hbdrc_pkg::in_word_t w, logic typed,
                              hbdrc_pkg::out_word_t want);
    hbdrc_pkg::out_word_t predicted;
    if (!sender_steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = predict_bridge_word(w);
    expected_words.push_back(typed ? want : predicted);
    if (!predicted.rejected && w.mode <= hbdrc_pkg::MODE_SAFE) commands_applied++;
  endtask

  // Stops offering words and waits until every result has come back.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic [1:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      hbdrc_pkg::CFG_DUTY_STEP: drv_cfg.duty_step = data[6:0];
      hbdrc_pkg::CFG_STEP_TICKS: drv_cfg.step_ticks = data;
      hbdrc_pkg::CFG_DEADTIME: drv_cfg.deadtime_ticks = data;
      default: ;
    endcase
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Each result word taken is compared with the oldest expected word.
  always @(posedge clk_i) begin
    hbdrc_pkg::out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        $error("result word with no command waiting for it");
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        check_field("bridge_state", 8'(want.bridge_state), 8'(out_data_o.bridge_state));
        check_field("pwm_duty_out", 8'(want.pwm_duty_out), 8'(out_data_o.pwm_duty_out));
        check_field("pwm_on", 8'(want.pwm_on), 8'(out_data_o.pwm_on));
        check_field("is_enabled", 8'(want.is_enabled), 8'(out_data_o.is_enabled));
        check_field("direction_now", 8'(want.direction_now),
                    8'(out_data_o.direction_now));
        check_field("duty_now", 8'(want.duty_now), 8'(out_data_o.duty_now));
        check_field("busy_res", 8'(want.busy_res), 8'(out_data_o.busy_res));
        check_field("rejected", 8'(want.rejected), 8'(out_data_o.rejected));
      end
    end
  end

  // Receiver: random stalls, one long hold-off that backs the block up, and
  // a stretch where it takes every word.
  initial begin
    int unsigned rx_cycle;
    rx_cycle = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (rx_cycle >= HOLD_OFF_FIRST && rx_cycle <= HOLD_OFF_LAST)
        out_ready_i <= 1'b0;
      else if (rx_cycle >= STEADY_FIRST && rx_cycle <= STEADY_LAST)
        out_ready_i <= 1'b1;
      else
        out_ready_i <= $urandom_range(99) >= IDLE_PERCENT;
    end
  end

  // Stimulus: directed rows, then one random phase per register setting.
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DIRECTED[i]) send_command(DIRECTED[i].cmd, DIRECTED[i].typed, DIRECTED[i].want);
    foreach (REG_PHASES[p]) begin
      settle();
      write_register(hbdrc_pkg::CFG_DUTY_STEP, 16'(REG_PHASES[p].duty_step));
      write_register(hbdrc_pkg::CFG_STEP_TICKS, REG_PHASES[p].step_ticks);
      write_register(hbdrc_pkg::CFG_DEADTIME, REG_PHASES[p].deadtime_ticks);
      cfg_valid_i <= 1'b0;
      sender_steady = p == 3;
      commands_applied = 0;
      while (commands_applied < (p == 0 ? BRIEF_ITEMS : PHASE_ITEMS))
        send_command(random_command(), PREDICT, NO_WORD);
    end
    settle();
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("hbridge_direction_ramp_control test passed");
    end else begin
      $display("hbridge_direction_ramp_control test failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2ms;
    $display("hbridge_direction_ramp_control test failed");
    $finish;
  end

endmodule
